// ===== hdl/rhdp_pkg.sv =====
// ----------------------------------------------------------------------------
// rhdp_pkg: shared types, tables and helpers
// Code tables, register indexes and the decoder state type.
// ----------------------------------------------------------------------------
package rhdp_pkg;

	localparam int MAX_WIDTH_DEF  = 16384;
	localparam int MAX_HEIGHT_DEF = 8192;
	localparam int BUF_BITS       = 40;
	localparam int MAX_RUN        = 8;
	localparam int NUM_TABLES     = 6;
	localparam int LAST_TABLE     = NUM_TABLES - 1;

	typedef enum logic [2:0] {
		REG_WIDTH, REG_HEIGHT, REG_SPLIT, REG_TABLE,
		REG_SEED_EE, REG_SEED_OE, REG_SEED_EO, REG_SEED_OO
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_CODE, ST_SYM, ST_DIFF, ST_EMIT, ST_FLUSH
	} dec_state_t;

	// symbol value that stands for the fixed difference -32768
	localparam logic [6:0] SYM_MIN_DIFF = 7'd16;

	typedef struct packed {
		logic               upd;
		logic signed [16:0] diff;
	} pred_cmd_t;

	typedef struct packed {
		logic [14:0] pixel;
		logic        img_end;
	} pred_stat_t;

	localparam logic [2:0] CODE_COUNT [NUM_TABLES][16] = '{
		'{3'd0,3'd1,3'd5,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd2,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0},
		'{3'd0,3'd1,3'd5,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd2,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0},
		'{3'd0,3'd1,3'd4,3'd2,3'd3,3'd1,3'd2,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0},
		'{3'd0,3'd1,3'd4,3'd3,3'd1,3'd1,3'd1,3'd1,3'd1,3'd2,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0},
		'{3'd0,3'd1,3'd5,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd2,3'd0,3'd0,3'd0,3'd0,3'd0},
		'{3'd0,3'd1,3'd4,3'd2,3'd2,3'd3,3'd1,3'd2,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0}
	};

	localparam logic [6:0] CODE_VALUE [NUM_TABLES][16] = '{
		'{7'd5,7'd4,7'd3,7'd6,7'd2,7'd7,7'd1,7'd0,7'd8,7'd9,7'd11,7'd10,7'd12,7'd0,7'd0,7'd0},
		'{7'h39,7'h5a,7'h38,7'h27,7'h16,7'd5,7'd4,7'd3,7'd2,7'd1,7'd0,7'd11,7'd12,7'd12,
		  7'd0,7'd0},
		'{7'd5,7'd4,7'd6,7'd3,7'd7,7'd2,7'd8,7'd1,7'd9,7'd0,7'd10,7'd11,7'd12,7'd0,7'd0,7'd0},
		'{7'd5,7'd6,7'd4,7'd7,7'd8,7'd3,7'd9,7'd2,7'd1,7'd0,7'd10,7'd11,7'd12,7'd13,7'd14,
		  7'd0},
		'{7'd8,7'h5c,7'h4b,7'h3a,7'h29,7'd7,7'd6,7'd5,7'd4,7'd3,7'd2,7'd1,7'd0,7'd13,7'd14,
		  7'd0},
		'{7'd7,7'd6,7'd8,7'd5,7'd9,7'd4,7'd10,7'd3,7'd11,7'd12,7'd2,7'd0,7'd1,7'd13,7'd14,
		  7'd0}
	};

	// number of codes in each table
	localparam logic [3:0] CODE_TOTAL [NUM_TABLES] = '{
		4'd14, 4'd14, 4'd13, 4'd15, 4'd15, 4'd15
	};

	function automatic int clamp_height(input logic [13:0] v, input int max_h);
		int h;
		h = int'(v);
		if (h < 1) h = 1;
		if (h > max_h) h = max_h;
		return h;
	endfunction

	function automatic int clamp_width(input logic [14:0] v, input int max_w);
		int w;
		w = int'(v);
		if (w < 2) w = 2;
		if (w > max_w) w = max_w;
		return w;
	endfunction

endpackage

// ===== hdl/rhdp_pred.sv =====
// ----------------------------------------------------------------------------
// rhdp_pred: predictor and pixel position unit
// Holds row/column position, the two column predictors and the row seeds.
// ----------------------------------------------------------------------------
module rhdp_pred #(
	parameter int MAX_WIDTH  = rhdp_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rhdp_pkg::MAX_HEIGHT_DEF,
	localparam int RW = $clog2(MAX_HEIGHT + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [14:0]           cfg_width,
	input  logic [13:0]           cfg_height,
	input  logic [15:0]           cfg_seed [4],
	input  rhdp_pkg::pred_cmd_t   cmd,
	output logic [RW-1:0]         row,
	output rhdp_pkg::pred_stat_t  stat
);
	import rhdp_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH + 1);

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [31:0]   pred_q [2];
	logic [31:0]   seed_q [4];
	logic [31:0]   seed_eff [4];
	logic [31:0]   base, sum;
	logic          first_pix, rp, cp, end_col, end_img;
	int            w_eff, h_eff;

	always_comb begin
		w_eff     = clamp_width(cfg_width, MAX_WIDTH);
		h_eff     = clamp_height(cfg_height, MAX_HEIGHT);
		first_pix = (row_q == '0) && (col_q == '0);
		rp        = row_q[0];
		cp        = col_q[0];
		for (int i = 0; i < 4; i++) begin
			seed_eff[i] = first_pix ? {16'd0, cfg_seed[i]} : seed_q[i];
		end
		base    = (col_q == '0) ? seed_eff[{rp, 1'b0}] : pred_q[cp];
		sum     = base + {{15{cmd.diff[16]}}, cmd.diff};
		end_col = (32'(col_q) + 32'd1) >= 32'(w_eff);
		end_img = end_col && ((32'(row_q) + 32'd1) >= 32'(h_eff));
		if (sum[31])
			stat.pixel = '0;
		else if (sum > 32'd32767)
			stat.pixel = 15'h7fff;
		else
			stat.pixel = sum[14:0];
		stat.img_end = end_img;
	end

	assign row = row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.upd) begin
			if (end_col) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			if (col_q == '0) pred_q[1] <= seed_eff[{rp, 1'b1}];
			pred_q[cp] <= sum;
			// first two columns write back into the row seeds
			for (int i = 0; i < 4; i++) begin
				if (32'(col_q) < 32'd2 && 2'(i) == {rp, cp})
					seed_q[i] <= sum;
				else if (first_pix)
					seed_q[i] <= seed_eff[i];
			end
		end
	end

endmodule

// ===== hdl/raw_huffman_delta_pixel_decoder.sv =====
// ----------------------------------------------------------------------------
// raw_huffman_delta_pixel_decoder: Huffman delta pixel decoder
// Bit-serial Huffman code walk with delta prediction and 15-bit clamping.
// ----------------------------------------------------------------------------
// Usage:
// Compressed bytes enter on in_valid/in_ready (data_byte, MSB first). Each
// word is appended to a 40-bit bit buffer, then codes are walked one bit per
// cycle from the oldest unused bit; difference bits are also shifted in one
// per cycle. A byte is loaded, then any partial symbol left in the buffer is
// walked afresh, then its complete symbols (up to eight) are decoded and any
// result still held is flushed to the output register.
// Up to eight pixels leave per byte on out_valid/out_ready; last_of_run
// marks the last pixel caused by a byte. One result is held back until the
// next symbol attempt tells whether it is the last of the run, so the first
// pixel of a byte leaves after the second symbol (or end of run) resolves.
// A stalled receiver holds the output register; the walker then waits with
// one more result in its holding register. in_ready is low while a byte is
// being worked on, and stays low for good after the image is complete or a
// bad code is met. Reset clears position, buffer and the stop flag and sets
// the registers to width 2, height 1. cfg_ready is always high; the user must
// make writes only while idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module raw_huffman_delta_pixel_decoder #(
	parameter int MAX_WIDTH  = rhdp_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rhdp_pkg::MAX_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [14:0] pixel,
	output logic        last_of_run,
	output logic        image_done,
	output logic        bad_code,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import rhdp_pkg::*;

	localparam int RW = $clog2(MAX_HEIGHT + 1);

	dec_state_t state_q, state_nx;

	logic [14:0] width_q;
	logic [13:0] height_q;
	logic [12:0] split_q;
	logic [2:0]  tsel_q;
	logic [15:0] seed_cfg_q [4];

	logic [BUF_BITS-1:0] buf_q;
	logic [5:0]          cnt_q;
	logic [4:0]          pos_q;
	logic [15:0]         code_q;
	logic [16:0]         first_q;
	logic [3:0]          index_q;
	logic [6:0]          sym_q;
	logic [3:0]          left_q;
	logic [14:0]         v_q;
	logic signed [16:0]  diff_q;
	logic                bad_q;
	logic [3:0]          n_q;
	logic                stopped_q;

	logic        pend_valid_q, pend_done_q, pend_bad_q;
	logic [14:0] pend_pix_q;
	logic        out_valid_q, out_last_q, out_done_q, out_bad_q;
	logic [14:0] out_pix_q;

	logic [RW-1:0] row;
	pred_cmd_t     pcmd;
	pred_stat_t    pstat;

	logic [2:0]  tab;
	logic        walk_bit, need_more, hit, bad_now, is_min, len_zero, fits;
	logic [15:0] code_nx;
	logic [16:0] off;
	logic [2:0]  cnt_cur;
	logic [16:0] first_nx;
	logic [3:0]  index_nx, len, nb;
	logic [2:0]  shl;
	logic [31:0] t_raw, t_fix;
	logic        accept, out_free, go, finish, run_full, push, push_last;
	int          h_eff;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 15'd2;
			height_q <= 14'd1;
			split_q  <= '0;
			tsel_q   <= '0;
			for (int i = 0; i < 4; i++) seed_cfg_q[i] <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WIDTH:   width_q       <= cfg_data[14:0];
				REG_HEIGHT:  height_q      <= cfg_data[13:0];
				REG_SPLIT:   split_q       <= cfg_data[12:0];
				REG_TABLE:   tsel_q        <= cfg_data[2:0];
				REG_SEED_EE: seed_cfg_q[0] <= cfg_data;
				REG_SEED_OE: seed_cfg_q[2] <= cfg_data;
				REG_SEED_EO: seed_cfg_q[1] <= cfg_data;
				REG_SEED_OO: seed_cfg_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// table in force for the next symbol
	always_comb begin
		h_eff = clamp_height(height_q, MAX_HEIGHT);
		tab   = (tsel_q > 3'(LAST_TABLE)) ? 3'(LAST_TABLE) : tsel_q;
		if (split_q != '0 && 32'(split_q) < 32'(h_eff) && 32'(row) >= 32'(split_q))
			tab = (tab == 3'(LAST_TABLE)) ? tab : tab + 3'd1;
	end

	// code walk and difference decode
	always_comb begin
		walk_bit  = buf_q[cnt_q - 6'd1 - {1'b0, pos_q}];
		need_more = {1'b0, pos_q} >= cnt_q;
		code_nx   = {code_q[14:0], walk_bit};
		cnt_cur   = CODE_COUNT[tab][pos_q[3:0]];
		off       = {1'b0, code_nx} - first_q;
		hit       = ({1'b0, code_nx} >= first_q) && (off < 17'(cnt_cur));
		first_nx  = (first_q + 17'(cnt_cur)) << 1;
		index_nx  = index_q + 4'(cnt_cur);
		bad_now   = !hit && (index_nx >= CODE_TOTAL[tab]);

		is_min    = (sym_q == SYM_MIN_DIFF);
		len       = sym_q[3:0];
		shl       = sym_q[6:4];
		nb        = (len > {1'b0, shl}) ? len - {1'b0, shl} : 4'd0;
		len_zero  = (len == 4'd0);
		fits      = ({1'b0, pos_q} + {2'b0, nb}) <= cnt_q;

		t_raw = (32'({v_q, 1'b1}) << shl) >> 1;
		t_fix = t_raw;
		if (len != 4'd0 && !t_raw[len - 4'd1])
			t_fix = t_raw - ((32'd1 << len) - ((shl == 3'd0) ? 32'd1 : 32'd0));
	end

	// handshake and flow control
	always_comb begin
		out_free  = !out_valid_q || out_ready;
		accept    = (state_q == ST_IDLE) && in_valid && !stopped_q;
		go        = !pend_valid_q || out_free;
		finish    = bad_q || pstat.img_end;
		run_full  = (n_q == 4'(MAX_RUN - 1));
		push      = ((state_q == ST_EMIT) && go && pend_valid_q)
		         || ((state_q == ST_FLUSH) && out_free);
		push_last = (state_q == ST_FLUSH);
		in_ready  = (state_q == ST_IDLE) && !stopped_q;
		pcmd.upd  = (state_q == ST_EMIT) && go && !bad_q;
		pcmd.diff = diff_q;
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept) state_nx = ST_CODE;
			ST_CODE: begin
				if (need_more)
					state_nx = pend_valid_q ? ST_FLUSH : ST_IDLE;
				else if (hit)
					state_nx = ST_SYM;
				else if (bad_now)
					state_nx = ST_EMIT;
			end
			ST_SYM: begin
				if (is_min)
					state_nx = ST_EMIT;
				else if (!fits)
					state_nx = pend_valid_q ? ST_FLUSH : ST_IDLE;
				else if (len_zero)
					state_nx = ST_EMIT;
				else
					state_nx = ST_DIFF;
			end
			ST_DIFF:  if (left_q == 4'd0) state_nx = ST_EMIT;
			ST_EMIT:  if (go) state_nx = (finish || run_full) ? ST_FLUSH : ST_CODE;
			ST_FLUSH: if (out_free) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			buf_q        <= '0;
			stopped_q    <= 1'b0;
			bad_q        <= 1'b0;
			n_q          <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				buf_q <= {buf_q[BUF_BITS-9:0], data_byte};
				cnt_q <= (cnt_q > 6'(BUF_BITS - 8)) ? 6'(BUF_BITS) : cnt_q + 6'd8;
				bad_q <= 1'b0;
				n_q   <= '0;
			end
			if (state_q == ST_CODE && !need_more && !hit && bad_now) bad_q <= 1'b1;
			if (state_q == ST_EMIT && go) begin
				cnt_q        <= cnt_q - {1'b0, pos_q};
				n_q          <= n_q + 4'd1;
				pend_valid_q <= 1'b1;
				if (finish) stopped_q <= 1'b1;
			end
			if (state_q == ST_FLUSH && out_free) pend_valid_q <= 1'b0;
			if (push)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// walker datapath and result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_CODE: begin
				pos_q  <= pos_q + 5'd1;
				code_q <= code_nx;
				if (hit) begin
					sym_q <= CODE_VALUE[tab][index_q + off[3:0]];
				end else begin
					first_q <= first_nx;
					index_q <= index_nx;
				end
			end
			ST_SYM: begin
				v_q    <= '0;
				left_q <= nb;
				if (is_min)
					diff_q <= -17'sd32768;
				else if (len_zero) begin
					diff_q <= '0;
					pos_q  <= pos_q + 5'(nb);
				end
			end
			ST_DIFF: begin
				if (left_q != 4'd0) begin
					v_q    <= {v_q[13:0], walk_bit};
					pos_q  <= pos_q + 5'd1;
					left_q <= left_q - 4'd1;
				end else begin
					diff_q <= t_fix[16:0];
				end
			end
			default: ;
		endcase
		if (accept || (state_q == ST_EMIT && go)) begin
			pos_q   <= '0;
			code_q  <= '0;
			first_q <= '0;
			index_q <= '0;
		end
		if (state_q == ST_EMIT && go) begin
			pend_pix_q  <= bad_q ? 15'd0 : pstat.pixel;
			pend_done_q <= !bad_q && pstat.img_end;
			pend_bad_q  <= bad_q;
		end
		if (push) begin
			out_pix_q  <= pend_pix_q;
			out_done_q <= pend_done_q;
			out_bad_q  <= pend_bad_q;
			out_last_q <= push_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel       = out_pix_q;
	assign last_of_run = out_last_q;
	assign image_done  = out_done_q;
	assign bad_code    = out_bad_q;

	rhdp_pred #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_pred (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_width  (width_q),
		.cfg_height (height_q),
		.cfg_seed   (seed_cfg_q),
		.cmd        (pcmd),
		.row        (row),
		.stat       (pstat)
	);

endmodule

// ===== hdl/rhdp_checker.sv =====
// ----------------------------------------------------------------------------
// rhdp_port_checker: port-level checks for the decoder
// Watches the top-level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module rhdp_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [14:0] pixel,
	input logic        last_of_run,
	input logic        image_done,
	input logic        bad_code
);

	// a word on the output holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel))
		else $error("output word dropped or changed while stalled");

	a_bad_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_code |-> pixel == 15'd0 && last_of_run && !image_done)
		else $error("bad code word malformed");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_done |-> last_of_run)
		else $error("image end not at end of run");

	// no more bytes once the stream has ended
	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && (image_done || bad_code) |=> !in_ready)
		else $error("input taken after stream end");

endmodule

bind raw_huffman_delta_pixel_decoder rhdp_port_checker u_rhdp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.pixel       (pixel),
	.last_of_run (last_of_run),
	.image_done  (image_done),
	.bad_code    (bad_code)
);

// ===== bench/rhdp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhdp_checker: scoreboard for the Huffman delta pixel decoder
// Tracks register writes and accepted bytes, decodes the stream on its own
// and compares every pixel word leaving the block with the oldest prediction.
// ----------------------------------------------------------------------------
module rhdp_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [14:0] pixel,
	input  logic        last_of_run,
	input  logic        image_done,
	input  logic        bad_code,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending,
	output logic        halted,
	output int          bytes_seen,
	output int          words_checked
);
	import rhdp_pkg::*;

	localparam int WIDTH_CAP  = 16384;
	localparam int HEIGHT_CAP = 8192;

	typedef enum int {SYM_SHORT, SYM_OK, SYM_BAD} sym_status_t;

	typedef struct packed {
		logic [14:0] pixel;
		logic        last;
		logic        done;
		logic        bad;
	} pixel_word_t;

	// canonical code lengths and symbol values of the six tables
	int unsigned len_count [6][16] = '{
		'{0,1,5,1,1,1,1,1,1,2,0,0,0,0,0,0},
		'{0,1,5,1,1,1,1,1,1,2,0,0,0,0,0,0},
		'{0,1,4,2,3,1,2,0,0,0,0,0,0,0,0,0},
		'{0,1,4,3,1,1,1,1,1,2,0,0,0,0,0,0},
		'{0,1,5,1,1,1,1,1,1,1,2,0,0,0,0,0},
		'{0,1,4,2,2,3,1,2,0,0,0,0,0,0,0,0}
	};
	int unsigned sym_value [6][16] = '{
		'{5,4,3,6,2,7,1,0,8,9,11,10,12,0,0,0},
		'{'h39,'h5a,'h38,'h27,'h16,5,4,3,2,1,0,11,12,12,0,0},
		'{5,4,6,3,7,2,8,1,9,0,10,11,12,0,0,0},
		'{5,6,4,7,8,3,9,2,1,0,10,11,12,13,14,0},
		'{8,'h5c,'h4b,'h3a,'h29,7,6,5,4,3,2,1,0,13,14,0},
		'{7,6,8,5,9,4,10,3,11,12,2,0,1,13,14,0}
	};

	int unsigned reg_val [8];
	logic [63:0] bits;
	int unsigned nbits;
	int unsigned row, col;
	logic [31:0] pred [2];
	logic [31:0] seed [4];
	bit          stop;
	pixel_word_t pixel_q [$];
	int          mismatches;

	function automatic int unsigned peek(input int unsigned pos, input int unsigned n);
		return int'((bits >> (nbits - pos - n)) & ((64'd1 << n) - 64'd1));
	endfunction

	function automatic int unsigned table_for_row();
		int unsigned h, t;
		h = (reg_val[REG_HEIGHT] == 0) ? 1 : reg_val[REG_HEIGHT];
		if (h > HEIGHT_CAP) h = HEIGHT_CAP;
		t = (reg_val[REG_TABLE] > 5) ? 5 : reg_val[REG_TABLE];
		if (reg_val[REG_SPLIT] != 0 && reg_val[REG_SPLIT] < h && row >= reg_val[REG_SPLIT])
			t = (t + 1 > 5) ? 5 : t + 1;
		return t;
	endfunction

	function automatic sym_status_t take_symbol(output logic [31:0] diff);
		int unsigned tab, code, first, idx, total, l, cnt, sym, len, shl, nb, used, v;
		logic [31:0] t;
		bit hit;
		tab = table_for_row();
		code = 0; first = 0; idx = 0; total = 0; sym = 0; hit = 0; diff = '0;
		for (int k = 0; k < 16; k++) total += len_count[tab][k];
		for (l = 1; l <= 16; l++) begin
			cnt = len_count[tab][l-1];
			if (l > nbits) return SYM_SHORT;
			code = (code << 1) | peek(l - 1, 1);
			if (code - first < cnt) begin
				sym = sym_value[tab][(idx + code - first) & 15];
				hit = 1;
				break;
			end
			idx += cnt;
			first = (first + cnt) << 1;
			if (idx >= total) return SYM_BAD;
		end
		if (!hit) return SYM_BAD;
		if (sym == 16) begin
			diff = 32'hFFFF8000;
			used = l;
		end else begin
			len = sym & 15;
			shl = sym >> 4;
			nb = (len > shl) ? len - shl : 0;
			if (l + nb > nbits) return SYM_SHORT;
			if (len != 0) begin
				v = nb ? peek(l, nb) : 0;
				t = (((v << 1) + 1) << shl) >> 1;
				if (t[len-1] == 1'b0) t -= (32'd1 << len) - ((shl == 0) ? 32'd1 : 32'd0);
				diff = t;
			end
			used = l + nb;
		end
		nbits -= used;
		bits &= (64'd1 << nbits) - 64'd1;
		return SYM_OK;
	endfunction

	task automatic decode_byte(input logic [7:0] b);
		int unsigned w, h, rp, cp, n;
		logic [31:0] diff, p;
		sym_status_t st;
		pixel_word_t wd;
		n = 0;
		if (stop) return;
		w = reg_val[REG_WIDTH];
		h = reg_val[REG_HEIGHT];
		if (w < 2) w = 2;
		if (w > WIDTH_CAP) w = WIDTH_CAP;
		if (h < 1) h = 1;
		if (h > HEIGHT_CAP) h = HEIGHT_CAP;
		bits = ((bits << 8) | b) & ((64'd1 << BUF_BITS) - 64'd1);
		nbits = (nbits + 8 > BUF_BITS) ? BUF_BITS : nbits + 8;
		while (n < MAX_RUN && !stop) begin
			st = take_symbol(diff);
			if (st == SYM_SHORT) break;
			if (st == SYM_BAD) begin
				wd = '{pixel: '0, last: 1'b0, done: 1'b0, bad: 1'b1};
				pixel_q.push_back(wd);
				n++;
				stop = 1;
				break;
			end
			if (row == 0 && col == 0) begin
				seed[0] = reg_val[REG_SEED_EE];
				seed[2] = reg_val[REG_SEED_OE];
				seed[1] = reg_val[REG_SEED_EO];
				seed[3] = reg_val[REG_SEED_OO];
			end
			rp = row & 1;
			cp = col & 1;
			if (col == 0) begin
				pred[0] = seed[rp*2];
				pred[1] = seed[rp*2+1];
			end
			pred[cp] += diff;
			if (col < 2) seed[rp*2+cp] = pred[cp];
			p = pred[cp];
			if (p[31]) p = 0;
			else if (p > 32767) p = 32767;
			wd = '{pixel: p[14:0], last: 1'b0, done: 1'b0, bad: 1'b0};
			n++;
			col++;
			if (col >= w) begin
				col = 0;
				row++;
				if (row >= h) begin
					wd.done = 1'b1;
					stop = 1;
				end
			end
			pixel_q.push_back(wd);
		end
		if (n > 0) pixel_q[$].last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_word_t exp_w;
		if (!arst_n) begin
			foreach (reg_val[i]) reg_val[i] = 0;
			reg_val[REG_WIDTH] = 2;
			reg_val[REG_HEIGHT] = 1;
			bits = '0; nbits = 0; row = 0; col = 0;
			pred[0] = '0; pred[1] = '0;
			foreach (seed[i]) seed[i] = '0;
			stop = 0;
			pixel_q.delete();
			mismatches = 0;
			fail_count <= 0;
			pending <= 0;
			halted <= 1'b0;
			bytes_seen <= 0;
			words_checked <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_WIDTH:  reg_val[cfg_index] = cfg_data[14:0];
					REG_HEIGHT: reg_val[cfg_index] = cfg_data[13:0];
					REG_SPLIT:  reg_val[cfg_index] = cfg_data[12:0];
					REG_TABLE:  reg_val[cfg_index] = cfg_data[2:0];
					default:    reg_val[cfg_index] = cfg_data;
				endcase
			end
			if (in_valid && in_ready) begin
				decode_byte(data_byte);
				bytes_seen <= bytes_seen + 1;
			end
			if (out_valid && out_ready) begin
				words_checked <= words_checked + 1;
				if (pixel_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0t] unexpected word: pixel=%0d last=%b done=%b bad=%b",
							$realtime, pixel, last_of_run, image_done, bad_code);
				end else begin
					exp_w = pixel_q.pop_front();
					if (exp_w.pixel !== pixel || exp_w.last !== last_of_run ||
							exp_w.done !== image_done || exp_w.bad !== bad_code) begin
						mismatches++;
						if (mismatches <= 10)
							$display("[%0t] mismatch: exp %0d/%b/%b/%b got %0d/%b/%b/%b",
								$realtime, exp_w.pixel, exp_w.last, exp_w.done, exp_w.bad,
								pixel, last_of_run, image_done, bad_code);
					end
				end
			end
			fail_count <= mismatches;
			pending <= pixel_q.size();
			halted <= stop;
		end
	end

endmodule

// ===== bench/tb_raw_huffman_delta_pixel_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_raw_huffman_delta_pixel_decoder: top of the decoder testbench
// Drives register setups and compressed bytes across several phases with
// random idling on both channels in most phases, then finishes the image and reports.
// ----------------------------------------------------------------------------
module tb_raw_huffman_delta_pixel_decoder;
	import rhdp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [14:0] pixel;
	logic        last_of_run, image_done, bad_code;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	int   fail_count, pending, bytes_seen, words_checked;
	logic halted;
	int   send_idle = 0;
	int   recv_idle = 0;
	int   cycles = 0;

	logic [7:0] directed [20] = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h7F,
		8'h55, 8'hAA, 8'h00, 8'hFF, 8'h01, 8'hFE, 8'hFF, 8'hFF, 8'hC3, 8'h3C, 8'h00, 8'h0F};

	always #1 clk = ~clk;

	raw_huffman_delta_pixel_decoder dut (.*);

	rhdp_checker u_checker (.*);

	always @(posedge clk)
		out_ready <= arst_n && ($urandom_range(0, 99) >= recv_idle);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic idle_mode(input int m);
		case (m)
			0: begin send_idle = 21; recv_idle = 46; end
			1: begin send_idle = 46; recv_idle = 21; end
			default: begin send_idle = 0; recv_idle = 0; end
		endcase
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// all words drained and the bit walker given time to finish
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0 || !in_ready) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_random(input int n);
		repeat (n) send_byte(8'($urandom_range(0, 255)));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tall image so nothing finishes early; split moves table 0 to table 1
		write_reg(REG_WIDTH, 16'd16);
		write_reg(REG_HEIGHT, 16'd16383);
		write_reg(REG_SPLIT, 16'd2);
		write_reg(REG_TABLE, 16'd0);
		write_reg(REG_SEED_EE, 16'd0);
		write_reg(REG_SEED_OE, 16'd65535);
		write_reg(REG_SEED_EO, 16'd1234);
		write_reg(REG_SEED_OO, 16'd30000);
		idle_mode(0);
		foreach (directed[i]) send_byte(directed[i]);
		send_random(90);
		drain();

		write_reg(REG_TABLE, 16'd2);
		write_reg(REG_SPLIT, 16'd0);
		write_reg(REG_WIDTH, 16'd6);
		write_reg(REG_HEIGHT, 16'd8192);
		idle_mode(1);
		send_random(90);
		drain();

		write_reg(REG_TABLE, 16'd3);
		write_reg(REG_SPLIT, 16'd8191);
		write_reg(REG_WIDTH, 16'd0);
		idle_mode(2);
		send_random(80);
		drain();

		// split already passed: table 4 steps up to table 5
		write_reg(REG_TABLE, 16'd4);
		write_reg(REG_SPLIT, 16'd1);
		write_reg(REG_WIDTH, 16'd32767);
		idle_mode(0);
		send_random(70);
		drain();

		write_reg(REG_TABLE, 16'd7);
		write_reg(REG_SPLIT, 16'd0);
		write_reg(REG_WIDTH, 16'd3);
		idle_mode(1);
		send_random(30);
		drain();

		// shrink the image so the current row ends it
		write_reg(REG_WIDTH, 16'd0);
		write_reg(REG_HEIGHT, 16'd0);
		idle_mode(2);
		while (!halted) begin
			send_byte(8'($urandom_range(0, 255)));
			in_valid <= 1'b0;
			repeat (2) @(posedge clk);
		end
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);

		$display("covered %0d bytes and %0d pixel words over six register setups",
			bytes_seen, words_checked);
		$display("tables 0..5 and out-of-range width, height and table values, image end");
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/rhdp_pkg.sv
hdl/rhdp_pred.sv
hdl/raw_huffman_delta_pixel_decoder.sv
hdl/rhdp_checker.sv
bench/rhdp_checker.sv
bench/tb_raw_huffman_delta_pixel_decoder.sv
